/* rtl/rbs_pkg.sv */
// Package for the retry back-off scheduler: widths, event and register codes,
// and the structs passed between the scheduler modules. No dependencies.
package rbs_pkg;

   localparam int TIME_W      = 32;
   localparam int DELAY_W     = 31;
   localparam int FAIL_W      = 3;
   localparam int KIND_W      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_BACKOFF = 4;
   localparam int BO_IDX_W    = 2;
   localparam int REQ_W       = 40;
   localparam int RSP_W       = 72;

   typedef logic [DELAY_W-1:0] delay_type;
   typedef logic [TIME_W-1:0]  stamp_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_POLL      = 3'd0,
      KIND_MARK      = 3'd1,
      KIND_ATTEMPT   = 3'd2,
      KIND_SUCCESS   = 3'd3,
      KIND_TRANSIENT = 3'd4,
      KIND_NO_SPACE  = 3'd5,
      KIND_REARM     = 3'd6
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_DELAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_3  = 3'd4;

   typedef struct packed {
      delay_type                   init_delay;
      delay_type [NUM_BACKOFF-1:0] backoff;
   } cfg_type;

   typedef struct packed {
      stamp_type         last_attempt;
      stamp_type         due_time;
      logic [FAIL_W-1:0] failures;
      logic              blocked;
      logic              pending;
      logic              attempt_due;
   } status_type;

endpackage

/* rtl/rbs_csr.sv */
// Configuration registers of the retry back-off scheduler: initial delay and
// the back-off table. Depends on rbs_pkg.
module rbs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbs_pkg::DELAY_W-1:0]     csr_wdata,
   output rbs_pkg::cfg_type                cfg
);
   import rbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INIT_DELAY: cfg_in.init_delay = csr_wdata;
            CSR_BACKOFF_0:  cfg_in.backoff[0] = csr_wdata;
            CSR_BACKOFF_1:  cfg_in.backoff[1] = csr_wdata;
            CSR_BACKOFF_2:  cfg_in.backoff[2] = csr_wdata;
            CSR_BACKOFF_3:  cfg_in.backoff[3] = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/rbs_engine.sv */
// Scheduler state and its per-event update: pending, blocked, failure count,
// due time and last attempt time. Depends on rbs_pkg.
module rbs_engine #(
   parameter int DELAY_STEPS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [rbs_pkg::KIND_W-1:0]   kind,
   input  logic [rbs_pkg::TIME_W-1:0]   now,
   input  rbs_pkg::cfg_type             cfg,
   output rbs_pkg::status_type          status
);
   import rbs_pkg::*;

   localparam logic [FAIL_W-1:0] FAIL_MAX = FAIL_W'(DELAY_STEPS);

   logic              pending_ff, pending_in;
   logic              blocked_ff, blocked_in;
   logic [FAIL_W-1:0] fail_ff, fail_in;
   stamp_type         due_ff, due_in;
   stamp_type         attempt_ff, attempt_in;

   stamp_type         candidate;
   stamp_type         since_due;
   stamp_type         until_due;
   logic              reached_old;
   logic              pull_in;
   logic [FAIL_W-1:0] fail_inc;
   logic [FAIL_W-1:0] fail_idx;
   delay_type         bo_delay;
   logic              reached_new;

   assign candidate   = now + {1'b0, cfg.init_delay};
   assign since_due   = now - due_ff;
   assign until_due   = due_ff - now;
   assign reached_old = !since_due[TIME_W-1];
   assign pull_in     = reached_old || ({1'b0, cfg.init_delay} < until_due);
   assign fail_inc    = (fail_ff < FAIL_MAX) ? fail_ff + 1'b1 : fail_ff;
   assign fail_idx    = fail_inc - 1'b1;
   assign bo_delay    = cfg.backoff[fail_idx[BO_IDX_W-1:0]];

   // Settle the new due flag per branch: now + d is reached only for d == 0,
   // and a due time of zero is reached while now is in its lower half.
   always_comb begin
      pending_in  = pending_ff;
      blocked_in  = blocked_ff;
      fail_in     = fail_ff;
      due_in      = due_ff;
      attempt_in  = attempt_ff;
      reached_new = reached_old;
      unique case (kind)
         KIND_MARK: begin
            if (!pending_ff) begin
               pending_in  = 1'b1;
               due_in      = candidate;
               reached_new = (cfg.init_delay == '0);
            end else if (!blocked_ff && fail_ff == '0 && pull_in) begin
               due_in      = candidate;
               reached_new = (cfg.init_delay == '0);
            end
         end
         KIND_ATTEMPT: begin
            attempt_in = now;
         end
         KIND_SUCCESS: begin
            pending_in  = 1'b0;
            blocked_in  = 1'b0;
            fail_in     = '0;
            due_in      = '0;
            attempt_in  = '0;
            reached_new = 1'b0;
         end
         KIND_TRANSIENT: begin
            pending_in  = 1'b1;
            fail_in     = fail_inc;
            due_in      = now + {1'b0, bo_delay};
            reached_new = (bo_delay == '0);
         end
         KIND_NO_SPACE: begin
            pending_in  = 1'b1;
            blocked_in  = 1'b1;
            due_in      = '0;
            reached_new = !now[TIME_W-1];
         end
         KIND_REARM: begin
            if (pending_ff && blocked_ff) begin
               blocked_in  = 1'b0;
               fail_in     = '0;
               due_in      = candidate;
               reached_new = (cfg.init_delay == '0);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         blocked_ff <= 1'b0;
         fail_ff    <= '0;
         due_ff     <= '0;
         attempt_ff <= '0;
      end else if (step) begin
         pending_ff <= pending_in;
         blocked_ff <= blocked_in;
         fail_ff    <= fail_in;
         due_ff     <= due_in;
         attempt_ff <= attempt_in;
      end
   end

   assign status.attempt_due  = pending_in && !blocked_in && reached_new;
   assign status.pending      = pending_in;
   assign status.blocked      = blocked_in;
   assign status.failures     = fail_in;
   assign status.due_time     = due_in;
   assign status.last_attempt = attempt_in;

endmodule

/* rtl/retry_backoff_scheduler.sv */
// Retry back-off scheduler top level: input register, scheduler engine,
// configuration registers and result register. Depends on rbs_pkg.
//
// Usage: each transfer on the req_ channel carries an event kind and the
// current millisecond time; the block answers every event with exactly one
// transfer on the rsp_ channel holding the updated status and whether an
// attempt is due now.
// The csr_ port writes the initial delay (index 0) and the four back-off
// delays (indexes 1 to 4); write it only while no event is in
// flight.
// A req_ transfer loads the input register; the engine then passes its result
// into the result register, which drives rsp_tvalid, once that register is free.
// Throughput: one event per cycle while the result is taken; the state update is
// combinational, done in the cycle the event leaves the input register.
// A stall on rsp_tready holds the result and the queued event; req_tready
// drops only when both registers are full and the result is not taken.
// Reset clears the scheduler state, the delay registers and both valid flags.
module retry_backoff_scheduler #(
   parameter int DELAY_STEPS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] kind, [34:3] now, [39:35] zero
   input  logic [rbs_pkg::REQ_W-1:0]       req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] attempt_due, [1] pending, [2] blocked_no_space, [5:3] failures,
   // [37:6] due_time, [69:38] last_attempt_time, [71:70] zero
   output logic [rbs_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_we,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbs_pkg::DELAY_W-1:0]     csr_wdata
);
   import rbs_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [KIND_W-1:0]   in_kind_ff;
   stamp_type           in_now_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_ff;
   logic                advance;
   logic                req_take;
   cfg_type             cfg;
   status_type          status;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_tdata[KIND_W-1:0];
         in_now_ff  <= req_tdata[KIND_W +: TIME_W];
      end
      if (advance) begin
         rsp_ff <= status;
      end
   end

   rbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rbs_engine #(
      .DELAY_STEPS (DELAY_STEPS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .kind   (in_kind_ff),
      .now    (in_now_ff),
      .cfg    (cfg),
      .status (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.last_attempt, rsp_ff.due_time, rsp_ff.failures,
                        rsp_ff.blocked, rsp_ff.pending, rsp_ff.attempt_due};

endmodule

/* rtl/rbs_checker.sv */
// Port-level checks for the retry back-off scheduler, attached to the top
// level by the bind below. Depends on rbs_pkg.
module rbs_checker #(
   parameter int DELAY_STEPS = 4
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [rbs_pkg::RSP_W-1:0]   rsp_tdata
);
   import rbs_pkg::*;

   localparam logic [FAIL_W-1:0] FAIL_MAX = FAIL_W'(DELAY_STEPS);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_due_needs_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1] && !rsp_tdata[2])
      else $error("attempt due while idle or blocked");

   a_blocked_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("blocked without pending work");

   a_fail_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:3] <= FAIL_MAX)
      else $error("failure count above saturation");

endmodule

bind retry_backoff_scheduler rbs_checker #(
   .DELAY_STEPS (DELAY_STEPS)
) u_rbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
